// File: sv/cb64_pkg.sv
// Shared types, constants and alphabet functions for the scrambled base64 codec.
// No dependencies; used by every module of the codec.
`default_nettype none

package cb64_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [8*64-1:0] ALPHABET =
        "tuvwxTUlmnopqrs7YZabcdefghij8yz0123456VWXkABCDEFGHIJKLMNOPQRS9+/";

    localparam logic [7:0] PAD_CHAR   = 8'd61;
    localparam logic [7:0] UPPER_BASE = 8'd155;
    localparam logic [7:0] LOWER_OFS  = 8'd64;
    localparam logic [7:0] DIGIT_OFS  = 8'd50;
    localparam logic [7:0] PLUS_CODE  = 8'd119;
    localparam logic [7:0] SLASH_CODE = 8'd121;

    localparam logic       MODE_ENCODE = 1'b0;
    localparam logic       MODE_DECODE = 1'b1;

    localparam logic [2:0] REG_MODE_ADDR = 3'd0;

    typedef struct packed {
        logic       wr;
        logic       mode;
    } cfg_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            eom;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        return ALPHABET[(63 - int'(v)) * 8 +: 8];
    endfunction

    function automatic logic [7:0] sym_to_char(input logic [5:0] v);
        logic [7:0] c;
        logic [7:0] r;
        c = alpha_char(v);
        if (c >= "A" && c <= "Z")
            r = UPPER_BASE - c;
        else if (c >= "a" && c <= "z")
            r = c - LOWER_OFS;
        else if (c >= "0" && c <= "9")
            r = c + DIGIT_OFS;
        else if (c == "+")
            r = PLUS_CODE;
        else if (c == "/")
            r = SLASH_CODE;
        else
            r = c;
        return r;
    endfunction

    // bit 6 set: unknown character
    function automatic logic [6:0] char_to_sym(input logic [7:0] d);
        logic [7:0] c;
        logic [6:0] r;
        if (d == SLASH_CODE)
            c = "/";
        else if (d == PLUS_CODE)
            c = "+";
        else if (d >= 8'd98 && d <= 8'd107)
            c = d - DIGIT_OFS;
        else if (d >= 8'd33 && d <= 8'd58)
            c = d + LOWER_OFS;
        else if (d >= "A" && d <= "Z")
            c = UPPER_BASE - d;
        else
            c = d;
        r = 7'b100_0000;
        for (int i = 0; i < 64; i++)
        begin
            if (c == alpha_char(6'(i)))
                r = {1'b0, 6'(i)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/cb64_front.sv
// Front end: holds mode and group state, accepts items and builds result jobs.
// Depends on cb64_pkg.
`default_nettype none

module cb64_front (
    input  logic           clk,
    input  logic           rst_n,
    input  cb64_pkg::cfg_t cfg,
    output logic           mode,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     data_in,
    input  logic           eom,
    input  logic           full,
    output logic           push,
    output cb64_pkg::job_t job
);
    import cb64_pkg::*;

    logic        mode_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [23:0] acc_reg, acc_next;
    logic [1:0]  pad_reg, pad_next;
    logic [2:0]  cnt;
    logic        accept;
    logic [6:0]  sym;
    logic [23:0] shifted;
    logic [7:0]  prev;

    assign in_ready = !full;
    assign accept   = in_valid && !full;
    assign mode     = mode_reg;
    assign sym      = char_to_sym(data_in);
    assign shifted  = {acc_reg[17:0], sym[6] ? 6'd0 : sym[5:0]};
    assign prev     = acc_reg[7:0];

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        pad_next   = pad_reg;
        job.bytes  = '0;
        cnt        = 3'd0;
        if (mode_reg == MODE_ENCODE)
        begin
            unique case (phase_reg)
                2'd1:
                begin
                    job.bytes[0] = sym_to_char({prev[1:0], data_in[7:4]});
                    job.bytes[1] = sym_to_char({data_in[3:0], 2'b00});
                    job.bytes[2] = PAD_CHAR;
                    cnt          = eom ? 3'd3 : 3'd1;
                    acc_next     = {16'd0, data_in};
                    phase_next   = 2'd2;
                end
                2'd2:
                begin
                    job.bytes[0] = sym_to_char({prev[3:0], data_in[7:6]});
                    job.bytes[1] = sym_to_char(data_in[5:0]);
                    cnt          = 3'd2;
                    acc_next     = '0;
                    phase_next   = 2'd0;
                end
                default:
                begin
                    job.bytes[0] = sym_to_char(data_in[7:2]);
                    job.bytes[1] = sym_to_char({data_in[1:0], 4'b0000});
                    job.bytes[2] = PAD_CHAR;
                    job.bytes[3] = PAD_CHAR;
                    cnt          = eom ? 3'd4 : 3'd1;
                    acc_next     = {16'd0, data_in};
                    phase_next   = 2'd1;
                end
            endcase
        end
        else
        begin
            if (sym[6] && pad_reg != 2'd0)
                pad_next = pad_reg - 2'd1;
            job.bytes[0] = shifted[23:16];
            job.bytes[1] = shifted[15:8];
            job.bytes[2] = shifted[7:0];
            if (phase_reg == 2'd3)
            begin
                cnt        = (pad_next > 2'd2) ? 3'd3 : (pad_next > 2'd1) ? 3'd2 : 3'd1;
                acc_next   = '0;
                phase_next = 2'd0;
            end
            else
            begin
                acc_next   = shifted;
                phase_next = phase_reg + 2'd1;
            end
        end
        if (eom)
        begin
            phase_next = 2'd0;
            acc_next   = '0;
            pad_next   = 2'd3;
        end
        job.last_idx = 2'(cnt - 3'd1);
        job.eom      = eom;
    end

    assign push = accept && (cnt != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ENCODE;
            phase_reg <= 2'd0;
            acc_reg   <= '0;
            pad_reg   <= 2'd3;
        end
        else if (cfg.wr)
        begin
            mode_reg  <= cfg.mode;
            phase_reg <= 2'd0;
            acc_reg   <= '0;
            pad_reg   <= 2'd3;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            pad_reg   <= pad_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/cb64_queue.sv
// Short job queue between front and back end, built from flops.
// Depends on cb64_pkg.
`default_nettype none

module cb64_queue #(
    parameter int DEPTH = cb64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cb64_pkg::job_t    wr_job,
    input  logic              pop,
    output cb64_pkg::job_t    rd_job,
    output cb64_pkg::q_stat_t stat
);
    import cb64_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_job     = mem[rd_ptr_reg];

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire

// File: sv/cb64_back.sv
// Back end: unpacks queued jobs into single result items behind an output register.
// Depends on cb64_pkg.
`default_nettype none

module cb64_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cb64_pkg::job_t    job,
    input  cb64_pkg::q_stat_t stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_data,
    output logic              out_last,
    output logic              out_done
);
    import cb64_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       done_reg;
    logic [1:0] sel_reg;
    logic       load;
    logic       at_end;

    assign load      = !valid_reg || out_ready;
    assign at_end    = (sel_reg == job.last_idx);
    assign pop       = load && !stat.empty && at_end;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;
    assign out_done  = done_reg;

    always_ff @(posedge clk)
    begin
        if (load && !stat.empty)
        begin
            data_reg <= job.bytes[sel_reg];
            last_reg <= at_end;
            done_reg <= at_end && job.eom;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= !stat.empty;
            if (!stat.empty)
                sel_reg <= at_end ? 2'd0 : sel_reg + 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: sv/base64_codec_scrambled_alphabet_unit.sv
// Scrambled-alphabet base64 codec: one item in per cycle while the job queue has room,
// one result item out per cycle while m_tready is high; jobs pass the queue, then the
// output register. Intake is set by the one-result-per-cycle output: encoding takes
// three items per four results, fewer near a padded end; decoding one item per cycle.
// Asynchronous active-low reset: mode encode, group state cleared, pad budget three.
// Depends on cb64_pkg, cb64_front, cb64_queue, cb64_back.
`default_nettype none

module base64_codec_scrambled_alphabet_unit #(
    parameter int QUEUE_DEPTH = cb64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_out
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser,   // [0] message_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cb64_pkg::*;

    cfg_t    cfg;
    logic    mode;
    logic    push;
    logic    pop;
    job_t    wr_job;
    job_t    rd_job;
    q_stat_t q_stat;

    assign pready   = 1'b1;
    assign cfg.wr   = psel && penable && pwrite && pready && (paddr[2] == REG_MODE_ADDR[2]);
    assign cfg.mode = pwdata[0];
    assign prdata   = (paddr[2] == REG_MODE_ADDR[2]) ? {31'd0, mode} : 32'd0;

    cb64_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .mode     (mode),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .data_in  (s_tdata),
        .eom      (s_tlast),
        .full     (q_stat.full),
        .push     (push),
        .job      (wr_job)
    );

    cb64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .stat   (q_stat)
    );

    cb64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (rd_job),
        .stat      (q_stat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast),
        .out_done  (m_tuser)
    );

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tuser || m_tlast))
        else $error("message end flagged on a result that does not close its run");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire
